FILE: rtl/core/wheel_speed_pi_loop_core_defines.svh
// ----------------------------------------------------------------------------
// wheel speed pi loop core: assertion macros
// implication checks, same cycle and next cycle, off in synthesis
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_PI_LOOP_CORE_DEFINES_SVH
`define WHEEL_SPEED_PI_LOOP_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define WSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsp: same cycle implication failed");

`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsp: next cycle implication failed");

`else

`define WSP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// shared types, constants and fixed point helpers of the wheel speed loop
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int WHEEL_W     = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_PERIOD = 3'd6;

    localparam logic signed [10:0] RST_SPEED_TARGET  = 11'sd0;
    localparam logic [15:0]        RST_PROP_GAIN     = 16'd0;
    localparam logic [15:0]        RST_INTEG_GAIN    = 16'd0;
    localparam logic signed [15:0] RST_INTEG_MAX     = 16'sh7FFF;
    localparam logic signed [15:0] RST_INTEG_MIN     = 16'sh8000;
    localparam logic [14:0]        RST_SPEED_LIMIT   = 15'd1000;
    localparam logic [7:0]         RST_SMOOTH_PERIOD = 8'd20;

    // filter weights in q.8
    localparam int W_FILT_OLD = 179;
    localparam int W_FILT_NEW = 77;

    // datapath widths
    localparam int FILT_W  = 20;
    localparam int WORD_W  = 32;
    localparam int ERR_W   = 21;
    localparam int DIFF_W  = 33;
    localparam int ACC_W   = 34;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TRUNC_W = PROD_W - 8;
    localparam int DIV_W   = 41;
    localparam int DIV_D_W = 8;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef logic signed [FILT_W-1:0]  filt_t;
    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [TRUNC_W-1:0] q_t;

    typedef struct packed {
        logic signed [10:0] speed_target;
        logic [15:0]        prop_gain;
        logic [15:0]        integ_gain;
        logic signed [15:0] integ_max;
        logic signed [15:0] integ_min;
        logic [14:0]        speed_limit;
        logic [7:0]         smooth_period;
    } cfg_t;

    typedef struct packed {
        logic signed [FILT_W-1:0] filt;
        logic signed [WORD_W-1:0] integ;
        logic signed [WORD_W-1:0] out_new;
        logic signed [WORD_W-1:0] out_old;
    } entry_t;

    typedef struct packed {
        logic               en;
        logic [WHEEL_W-1:0] addr;
        entry_t             data;
    } ram_wr_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // divide by 256, truncating toward zero
    function automatic q_t trunc256(input prod_t x);
        prod_t b;
        b = x + (x[PROD_W-1] ? prod_t'(255) : prod_t'(0));
        return $signed(b[PROD_W-1:8]);
    endfunction

    function automatic word_t sat_s32(input prod_t x);
        word_t r;
        if (x > prod_t'(64'sh7FFF_FFFF))
            r = 32'sh7FFF_FFFF;
        else if (x < prod_t'(-64'sh8000_0000))
            r = 32'sh8000_0000;
        else
            r = x[WORD_W-1:0];
        return r;
    endfunction

    function automatic filt_t sat_s20(input prod_t x);
        filt_t r;
        if (x > prod_t'(64'sd524287))
            r = 20'sh7FFFF;
        else if (x < prod_t'(-64'sd524288))
            r = 20'sh80000;
        else
            r = x[FILT_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/wsp_if.sv
// ----------------------------------------------------------------------------
// wsp channel interfaces
// valid/ready channels for input words, result words and register writes
// ----------------------------------------------------------------------------
interface wsp_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [1:0]         wheel;
    logic signed [15:0] measured_speed;
    logic [7:0]         slot;

    modport source (output valid, output opcode, output wheel, output measured_speed,
                    output slot, input ready);
    modport sink (input valid, input opcode, input wheel, input measured_speed,
                  input slot, output ready);
endinterface

interface wsp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         wheel_out;
    logic signed [31:0] control_value;

    modport source (output valid, output wheel_out, output control_value, input ready);
    modport sink (input valid, input wheel_out, input control_value, output ready);
endinterface

interface wsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/wsp_state_ram.sv
// ----------------------------------------------------------------------------
// wsp_state_ram
// per wheel state memory, one read and one write port, registered read data;
// entries never written read as zero
// ----------------------------------------------------------------------------
module wsp_state_ram (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [wsp_pkg::WHEEL_W-1:0]  rd_addr,
    input  wsp_pkg::ram_wr_t             wr,
    output wsp_pkg::entry_t              rd_data
);

    wsp_pkg::entry_t mem [wsp_pkg::WHEEL_COUNT];
    wsp_pkg::entry_t rdata_reg;

    logic [wsp_pkg::WHEEL_COUNT-1:0] valid_reg;
    logic [wsp_pkg::WHEEL_COUNT-1:0] valid_next;
    logic                            rvalid_reg;
    logic                            rvalid_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        rvalid_next = rvalid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
        if (rd_en)
        begin
            rvalid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: rtl/core/wsp_mul.sv
// ----------------------------------------------------------------------------
// wsp_mul
// shared signed 33 x 17 multiplier with registered product
// ----------------------------------------------------------------------------
module wsp_mul (
    input  logic              clk,
    input  wsp_pkg::mul_a_t   a,
    input  wsp_pkg::mul_b_t   b,
    output wsp_pkg::prod_t    p
);

    wsp_pkg::prod_t p_reg;
    wsp_pkg::prod_t p_next;

    always_comb
    begin
        p_next = wsp_pkg::prod_t'(a) * wsp_pkg::prod_t'(b);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/wsp_div.sv
// ----------------------------------------------------------------------------
// wsp_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wsp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  wsp_pkg::div_req_t  req,
    output wsp_pkg::div_rsp_t  rsp
);

    logic [wsp_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [wsp_pkg::DIV_D_W-1:0]   rem_reg, rem_next;
    logic [wsp_pkg::DIV_D_W-1:0]   dsr_reg, dsr_next;
    logic [wsp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [wsp_pkg::DIV_D_W:0]     trial;
    logic                          fits;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[wsp_pkg::DIV_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});

        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = wsp_pkg::DIV_CNT_W'(wsp_pkg::DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract if the divisor fits
            rem_next = fits ? trial[wsp_pkg::DIV_D_W-1:0] - dsr_reg
                            : trial[wsp_pkg::DIV_D_W-1:0];
            quo_next = {quo_reg[wsp_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wsp_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/core/wsp_seq.sv
// ----------------------------------------------------------------------------
// wsp_seq
// sequencer: reads a wheel entry, runs the filter, pi update or smoothing
// via the shared multiplier and divider, writes back pi updates, holds result
// ----------------------------------------------------------------------------
`include "wheel_speed_pi_loop_core_defines.svh"

module wsp_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    wsp_in_if.sink                       item,
    wsp_out_if.source                    result,
    input  wsp_pkg::cfg_t                cfg_regs,
    output logic                         ram_rd_en,
    output logic [wsp_pkg::WHEEL_W-1:0]  ram_rd_addr,
    output wsp_pkg::ram_wr_t             ram_wr,
    input  wsp_pkg::entry_t              ent,
    output wsp_pkg::mul_a_t              mul_a,
    output wsp_pkg::mul_b_t              mul_b,
    input  wsp_pkg::prod_t               prod,
    output wsp_pkg::div_req_t            div_req,
    input  wsp_pkg::div_rsp_t            div_rsp
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_F1    = 4'd1;
    localparam logic [3:0] ST_F2    = 4'd2;
    localparam logic [3:0] ST_F3    = 4'd3;
    localparam logic [3:0] ST_F4    = 4'd4;
    localparam logic [3:0] ST_ERR   = 4'd5;
    localparam logic [3:0] ST_PMUL  = 4'd6;
    localparam logic [3:0] ST_IMUL  = 4'd7;
    localparam logic [3:0] ST_IACC  = 4'd8;
    localparam logic [3:0] ST_CLAMP = 4'd9;
    localparam logic [3:0] ST_UPD   = 4'd10;
    localparam logic [3:0] ST_D1    = 4'd11;
    localparam logic [3:0] ST_D2    = 4'd12;
    localparam logic [3:0] ST_D3    = 4'd13;
    localparam logic [3:0] ST_DWAIT = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    logic [3:0]                  state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_wheel_reg, out_wheel_next;
    wsp_pkg::word_t              out_value_reg, out_value_next;

    logic                        op_reg, op_next;
    logic [1:0]                  wheel_reg, wheel_next;
    logic signed [15:0]          spd_reg, spd_next;
    logic [7:0]                  slot_reg, slot_next;
    wsp_pkg::acc_t               acc_reg, acc_next;
    wsp_pkg::filt_t              f_reg, f_next;
    wsp_pkg::err_t               err_reg, err_next;
    wsp_pkg::q_t                 p_reg, p_next;
    wsp_pkg::word_t              integ_reg, integ_next;
    wsp_pkg::diff_t              diff_reg, diff_next;
    logic                        neg_reg, neg_next;
    wsp_pkg::word_t              res_reg, res_next;

    logic                        accept;
    logic                        out_load;
    logic                        wheel_ok;
    logic signed [16:0]          spd_w;
    logic signed [16:0]          lim_w;
    logic                        spd_over;
    logic [8:0]                  slot_p1;

    assign accept   = item.valid && item.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign wheel_ok = (32'(item.wheel) < 32'(wsp_pkg::WHEEL_COUNT));
    assign spd_w    = 17'(item.measured_speed);
    assign lim_w    = $signed({2'b00, cfg_regs.speed_limit});
    assign spd_over = (spd_w > lim_w) || (spd_w < -lim_w);
    assign slot_p1  = {1'b0, slot_reg} + 9'd1;

    assign item.ready  = (state_reg == ST_IDLE);
    assign ram_rd_en   = accept;
    assign ram_rd_addr = item.wheel;

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_F1:
            begin
                mul_a = wsp_pkg::mul_a_t'(ent.filt);
                mul_b = wsp_pkg::mul_b_t'(wsp_pkg::W_FILT_OLD);
            end
            ST_F2:
            begin
                mul_a = wsp_pkg::mul_a_t'(spd_reg);
                mul_b = wsp_pkg::mul_b_t'(wsp_pkg::W_FILT_NEW);
            end
            ST_PMUL:
            begin
                mul_a = wsp_pkg::mul_a_t'(err_reg);
                mul_b = $signed({1'b0, cfg_regs.prop_gain});
            end
            ST_IMUL:
            begin
                mul_a = wsp_pkg::mul_a_t'(err_reg);
                mul_b = $signed({1'b0, cfg_regs.integ_gain});
            end
            ST_D2:
            begin
                mul_a = wsp_pkg::mul_a_t'(diff_reg);
                mul_b = $signed({8'h00, slot_p1});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        wsp_pkg::q_t    ipart;
        wsp_pkg::q_t    imax_q;
        wsp_pkg::q_t    imin_q;
        wsp_pkg::word_t integ_c;
        wsp_pkg::prod_t mag;
        wsp_pkg::prod_t qs;

        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_wheel_next = out_wheel_reg;
        out_value_next = out_value_reg;
        op_next        = op_reg;
        wheel_next     = wheel_reg;
        spd_next       = spd_reg;
        slot_next      = slot_reg;
        acc_next       = acc_reg;
        f_next         = f_reg;
        err_next       = err_reg;
        p_next         = p_reg;
        integ_next     = integ_reg;
        diff_next      = diff_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;

        ram_wr         = '0;
        div_req        = '0;

        ipart   = wsp_pkg::trunc256(wsp_pkg::prod_t'(integ_reg));
        imax_q  = wsp_pkg::q_t'(cfg_regs.integ_max);
        imin_q  = wsp_pkg::q_t'(cfg_regs.integ_min);
        integ_c = integ_reg;
        mag     = prod[wsp_pkg::PROD_W-1] ? -prod : prod;
        qs      = wsp_pkg::prod_t'({9'd0, div_rsp.quotient});
        if (neg_reg)
        begin
            qs = -qs;
        end

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = item.opcode;
                    wheel_next = item.wheel;
                    spd_next   = spd_over ? 16'sd0 : item.measured_speed;
                    slot_next  = item.slot;
                    if (!wheel_ok)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (item.opcode)
                    begin
                        state_next = ST_D1;
                    end
                    else
                    begin
                        state_next = ST_F1;
                    end
                end
            end
            ST_F1:
            begin
                state_next = ST_F2;
            end
            ST_F2:
            begin
                acc_next   = wsp_pkg::acc_t'(prod);
                state_next = ST_F3;
            end
            ST_F3:
            begin
                acc_next   = acc_reg + $signed({prod[25:0], 8'h00});
                state_next = ST_F4;
            end
            ST_F4:
            begin
                f_next     = wsp_pkg::sat_s20(wsp_pkg::prod_t'(
                                 wsp_pkg::trunc256(wsp_pkg::prod_t'(acc_reg))));
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                err_next   = wsp_pkg::err_t'($signed({cfg_regs.speed_target, 8'h00}))
                             - wsp_pkg::err_t'(f_reg);
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                state_next = ST_IMUL;
            end
            ST_IMUL:
            begin
                p_next     = wsp_pkg::trunc256(prod);
                state_next = ST_IACC;
            end
            ST_IACC:
            begin
                integ_next = wsp_pkg::sat_s32(wsp_pkg::prod_t'(ent.integ)
                                              + wsp_pkg::prod_t'(wsp_pkg::trunc256(prod)));
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // upper bound first, lower bound wins if they cross
                if (ipart > imax_q)
                begin
                    integ_c = wsp_pkg::word_t'($signed({cfg_regs.integ_max, 8'h00}));
                    ipart   = imax_q;
                end
                if (ipart < imin_q)
                begin
                    integ_c = wsp_pkg::word_t'($signed({cfg_regs.integ_min, 8'h00}));
                end
                integ_next = integ_c;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                res_next            = wsp_pkg::sat_s32(wsp_pkg::prod_t'(p_reg)
                                                       + wsp_pkg::prod_t'(integ_reg));
                ram_wr.en           = 1'b1;
                ram_wr.addr         = wheel_reg;
                ram_wr.data.filt    = f_reg;
                ram_wr.data.integ   = integ_reg;
                ram_wr.data.out_new = res_next;
                ram_wr.data.out_old = ent.out_new;
                state_next          = ST_DONE;
            end
            ST_D1:
            begin
                diff_next  = wsp_pkg::diff_t'(ent.out_new) - wsp_pkg::diff_t'(ent.out_old);
                state_next = ST_D2;
            end
            ST_D2:
            begin
                state_next = ST_D3;
            end
            ST_D3:
            begin
                neg_next         = prod[wsp_pkg::PROD_W-1];
                div_req.start    = 1'b1;
                div_req.dividend = mag[wsp_pkg::DIV_W-1:0];
                div_req.divisor  = (cfg_regs.smooth_period == 8'd0) ? 8'd1
                                                                     : cfg_regs.smooth_period;
                state_next       = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    res_next   = wsp_pkg::sat_s32(qs + wsp_pkg::prod_t'(ent.out_old));
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_wheel_next = wheel_reg;
                    out_value_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_wheel_reg <= out_wheel_next;
        out_value_reg <= out_value_next;
        op_reg        <= op_next;
        wheel_reg     <= wheel_next;
        spd_reg       <= spd_next;
        slot_reg      <= slot_next;
        acc_reg       <= acc_next;
        f_reg         <= f_next;
        err_reg       <= err_next;
        p_reg         <= p_next;
        integ_reg     <= integ_next;
        diff_reg      <= diff_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.wheel_out     = out_wheel_reg;
    assign result.control_value = out_value_reg;

    `WSP_ASSERT_NEXT(a_accept_closes, clk, rst_n, accept, !item.ready)
    `WSP_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)
    `WSP_ASSERT_IMP(a_dwait_div_live, clk, rst_n, state_reg == ST_DWAIT,
                    div_rsp.busy || div_rsp.done)
    `WSP_ASSERT_IMP(a_write_speed_only, clk, rst_n, ram_wr.en,
                    !op_reg && (state_reg == ST_UPD))

endmodule

FILE: rtl/core/wheel_speed_pi_loop_core.sv
// ----------------------------------------------------------------------------
// wheel_speed_pi_loop_core
// Per wheel speed PI regulator with output smoothing. A speed word (opcode 0)
// filters the measured speed, updates the integral and the output of its
// wheel and returns the new output; an interpolation word (opcode 1) returns
// old + (new - old) * (slot + 1) / period and leaves the state alone. One
// word is worked on at a time: a speed word reads, modifies and writes the
// state memory through one shared 33 x 17 multiplier; an interpolation
// word waits on the 41 step restoring divider. The next word is taken as
// soon as the result is in the output register, even while it waits there.
// The wheel state lives in a small memory whose entries read as zero until
// first written after reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module wheel_speed_pi_loop_core (
    input  logic       clk,
    input  logic       rst_n,
    wsp_in_if.sink     item,
    wsp_out_if.source  result,
    wsp_cfg_if.sink    cfg
);

    wsp_pkg::cfg_t                cfg_reg, cfg_next;
    logic                         ram_rd_en;
    logic [wsp_pkg::WHEEL_W-1:0]  ram_rd_addr;
    wsp_pkg::ram_wr_t             ram_wr;
    wsp_pkg::entry_t              ent;
    wsp_pkg::mul_a_t              mul_a;
    wsp_pkg::mul_b_t              mul_b;
    wsp_pkg::prod_t               prod;
    wsp_pkg::div_req_t            div_req;
    wsp_pkg::div_rsp_t            div_rsp;

    assign cfg.ready = 1'b1;

    // register writes, data truncated to each register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                wsp_pkg::REG_SPEED_TARGET:  cfg_next.speed_target  = $signed(cfg.data[10:0]);
                wsp_pkg::REG_PROP_GAIN:     cfg_next.prop_gain     = cfg.data;
                wsp_pkg::REG_INTEG_GAIN:    cfg_next.integ_gain    = cfg.data;
                wsp_pkg::REG_INTEG_MAX:     cfg_next.integ_max     = $signed(cfg.data);
                wsp_pkg::REG_INTEG_MIN:     cfg_next.integ_min     = $signed(cfg.data);
                wsp_pkg::REG_SPEED_LIMIT:   cfg_next.speed_limit   = cfg.data[14:0];
                wsp_pkg::REG_SMOOTH_PERIOD: cfg_next.smooth_period = cfg.data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_target  <= wsp_pkg::RST_SPEED_TARGET;
            cfg_reg.prop_gain     <= wsp_pkg::RST_PROP_GAIN;
            cfg_reg.integ_gain    <= wsp_pkg::RST_INTEG_GAIN;
            cfg_reg.integ_max     <= wsp_pkg::RST_INTEG_MAX;
            cfg_reg.integ_min     <= wsp_pkg::RST_INTEG_MIN;
            cfg_reg.speed_limit   <= wsp_pkg::RST_SPEED_LIMIT;
            cfg_reg.smooth_period <= wsp_pkg::RST_SMOOTH_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wsp_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .wr      (ram_wr),
        .rd_data (ent)
    );

    wsp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    wsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    wsp_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .cfg_regs    (cfg_reg),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_wr      (ram_wr),
        .ent         (ent),
        .mul_a       (mul_a),
        .mul_b       (mul_b),
        .prod        (prod),
        .div_req     (div_req),
        .div_rsp     (div_rsp)
    );

endmodule

FILE: bench/wheel_speed_pi_loop_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_pi_loop_core_tb
// Self-checking bench for the per wheel speed PI regulator. A short table of
// directed words and register writes is followed by random words under six
// register settings, extremes included. Each accepted word runs through a
// bit-true predictor of the filter, integral clamp, output and interpolation;
// results are compared in order against the queue of predicted control words.
// Both channels idle at random, the result side also holds off for a long
// stretch so the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module wheel_speed_pi_loop_core_tb;

    localparam logic   OP_SPEED    = 1'b0;
    localparam logic   OP_INTERP   = 1'b1;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     IDLE_PCT    = 34;
    localparam int     CALM_FROM   = 900;
    localparam int     CALM_TO     = 1150;
    localparam int     HOLD_AT     = 600;
    localparam int     HOLD_CYCLES = 400;
    localparam int     PHASE_COUNT = 6;
    localparam int     PHASE_WORDS = 250;
    localparam int     REPORT_MAX  = 10;
    localparam longint Q_ONE       = 256;
    localparam longint FILT_OLD_Q8 = 179;
    localparam longint FILT_NEW_Q8 = 77;
    localparam longint FILT_HI     = 524287;
    localparam longint FILT_LO     = -524288;
    localparam longint S32_HI      = 64'sd2147483647;
    localparam longint S32_LO      = -64'sd2147483648;

    typedef enum logic { ROW_REG, ROW_WORD } row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [wsp_pkg::CFG_IDX_W-1:0]    idx;
        logic [wsp_pkg::CFG_DATA_W-1:0]   data;
        logic                             op;
        logic [wsp_pkg::WHEEL_W-1:0]      wheel;
        logic signed [15:0]               speed;
        logic [7:0]                       slot;
        bit                               typed;
        wsp_pkg::word_t                   value;
    } row_t;

    typedef struct {
        logic [wsp_pkg::WHEEL_W-1:0] wheel;
        wsp_pkg::word_t              value;
    } ctrl_t;

    logic clk;
    logic rst_n;

    wsp_in_if  in_ch ();
    wsp_out_if out_ch ();
    wsp_cfg_if reg_ch ();

    wheel_speed_pi_loop_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (reg_ch)
    );

    wsp_pkg::cfg_t regs_mirror = '{wsp_pkg::RST_SPEED_TARGET, wsp_pkg::RST_PROP_GAIN,
                                   wsp_pkg::RST_INTEG_GAIN, wsp_pkg::RST_INTEG_MAX,
                                   wsp_pkg::RST_INTEG_MIN, wsp_pkg::RST_SPEED_LIMIT,
                                   wsp_pkg::RST_SMOOTH_PERIOD};
    longint filt_est  [wsp_pkg::WHEEL_COUNT] = '{default: 0};
    longint integ_acc [wsp_pkg::WHEEL_COUNT] = '{default: 0};
    longint ctrl_now  [wsp_pkg::WHEEL_COUNT] = '{default: 0};
    longint ctrl_prev [wsp_pkg::WHEEL_COUNT] = '{default: 0};
    ctrl_t  ctrl_expected [$];
    int     words_sent    = 0;
    int     words_checked = 0;
    int     fail_count    = 0;
    int     cycles        = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     ctrl_expected.size());
            $display("[wheel_speed_pi_loop_core] ERROR");
            $finish;
        end
    end

    function automatic longint clamp64(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void apply_reg(input logic [wsp_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [wsp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            wsp_pkg::REG_SPEED_TARGET:  regs_mirror.speed_target  = data[10:0];
            wsp_pkg::REG_PROP_GAIN:     regs_mirror.prop_gain     = data;
            wsp_pkg::REG_INTEG_GAIN:    regs_mirror.integ_gain    = data;
            wsp_pkg::REG_INTEG_MAX:     regs_mirror.integ_max     = data;
            wsp_pkg::REG_INTEG_MIN:     regs_mirror.integ_min     = data;
            wsp_pkg::REG_SPEED_LIMIT:   regs_mirror.speed_limit   = data[14:0];
            wsp_pkg::REG_SMOOTH_PERIOD: regs_mirror.smooth_period = data[7:0];
            default: ;
        endcase
    endfunction

    // advances the wheel state on a speed word and returns the control word for one input word
    function automatic wsp_pkg::word_t predict_control(input logic op,
                                                       input logic [wsp_pkg::WHEEL_W-1:0] wh,
                                                       input logic signed [15:0] speed,
                                                       input logic [7:0] slot);
        longint s, lim, tgt, kp, ki, imax, imin, f, err, p, acc, ipart, per, sl, r;
        s    = speed;
        lim  = regs_mirror.speed_limit;
        tgt  = $signed(regs_mirror.speed_target);
        kp   = regs_mirror.prop_gain;
        ki   = regs_mirror.integ_gain;
        imax = $signed(regs_mirror.integ_max);
        imin = $signed(regs_mirror.integ_min);
        per  = regs_mirror.smooth_period;
        sl   = slot;
        if (op == OP_SPEED)
        begin
            if (s > lim || s < -lim)
                s = 0;
            f = clamp64((FILT_OLD_Q8 * filt_est[wh] + FILT_NEW_Q8 * s * Q_ONE) / Q_ONE,
                        FILT_LO, FILT_HI);
            filt_est[wh] = f;
            err = tgt * Q_ONE - f;
            p   = err * kp / Q_ONE;
            acc = clamp64(integ_acc[wh] + err * ki / Q_ONE, S32_LO, S32_HI);
            ipart = acc / Q_ONE;
            // upper bound first, so a crossed pair leaves the lower bound in force
            if (ipart > imax)
            begin
                acc   = imax * Q_ONE;
                ipart = imax;
            end
            if (ipart < imin)
                acc = imin * Q_ONE;
            integ_acc[wh] = acc;
            ctrl_prev[wh] = ctrl_now[wh];
            ctrl_now[wh]  = clamp64(p + acc, S32_LO, S32_HI);
            r = ctrl_now[wh];
        end
        else
        begin
            if (per == 0)
                per = 1;
            r = clamp64((ctrl_now[wh] - ctrl_prev[wh]) * (sl + 1) / per + ctrl_prev[wh],
                        S32_LO, S32_HI);
        end
        return wsp_pkg::word_t'(r);
    endfunction

    function automatic row_t reg_row(input logic [wsp_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [wsp_pkg::CFG_DATA_W-1:0] data);
        row_t r;
        r = '{kind: ROW_REG, idx: idx, data: data, op: OP_SPEED, wheel: '0, speed: '0,
              slot: '0, typed: 1'b0, value: '0};
        return r;
    endfunction

    function automatic row_t word_row(input logic op, input logic [wsp_pkg::WHEEL_W-1:0] wh,
                                      input logic signed [15:0] speed, input logic [7:0] slot,
                                      input bit typed, input wsp_pkg::word_t value);
        row_t r;
        r = '{kind: ROW_WORD, idx: '0, data: '0, op: op, wheel: wh, speed: speed,
              slot: slot, typed: typed, value: value};
        return r;
    endfunction

    function automatic bit sender_rests();
        if (words_sent >= CALM_FROM && words_sent < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic offer_word(input logic op, input logic [wsp_pkg::WHEEL_W-1:0] wh,
                              input logic signed [15:0] speed, input logic [7:0] slot,
                              input bit typed, input wsp_pkg::word_t typed_value);
        ctrl_t          e;
        wsp_pkg::word_t v;
        while (sender_rests())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= op;
        in_ch.wheel          <= wh;
        in_ch.measured_speed <= speed;
        in_ch.slot           <= slot;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        v = predict_control(op, wh, speed, slot);
        e.wheel = wh;
        e.value = typed ? typed_value : v;
        ctrl_expected.push_back(e);
        words_sent++;
    endtask

    task automatic offer_random_word();
        logic                        op;
        logic [wsp_pkg::WHEEL_W-1:0] wh;
        logic signed [15:0]          speed;
        logic [7:0]                  slot;
        int                          lim, per, pick;
        lim  = regs_mirror.speed_limit;
        per  = (regs_mirror.smooth_period == 0) ? 1 : regs_mirror.smooth_period;
        op   = ($urandom_range(99) < 55) ? OP_SPEED : OP_INTERP;
        wh   = $urandom_range(wsp_pkg::WHEEL_COUNT - 1);
        pick = $urandom_range(99);
        if (pick < 70)
            speed = 16'(int'($urandom_range(2 * lim)) - lim);
        else if (pick < 85)
        begin
            case ($urandom_range(5))
                0:       speed = 16'sh7FFF;
                1:       speed = 16'sh8000;
                2:       speed = 16'(lim);
                3:       speed = 16'(-lim);
                4:       speed = 16'(lim + 1);
                default: speed = 16'(-lim - 1);
            endcase
        end
        else
            speed = 16'($urandom);
        if ($urandom_range(99) < 75)
            slot = 8'($urandom_range(per - 1));
        else
            slot = 8'($urandom);
        offer_word(op, wh, speed, slot, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [wsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wsp_pkg::CFG_DATA_W-1:0] data);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= data;
        @(posedge clk);
        while (!reg_ch.ready)
            @(posedge clk);
        apply_reg(idx, data);
        reg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (ctrl_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_setting(input int ph);
        int tgt, kp, ki, imx, imn, lim, per;
        case (ph)
            0:
            begin
                tgt = int'($urandom_range(2000)) - 1000;
                kp  = $urandom_range(1023);
                ki  = $urandom_range(255);
                imx = 32767;
                imn = -32768;
                lim = 1000;
                per = 20;
            end
            1:
            begin
                tgt = 1000;
                kp  = 65535;
                ki  = 65535;
                imx = 32767;
                imn = -32768;
                lim = 32767;
                per = 255;
            end
            2:
            begin
                tgt = -1000;
                kp  = 0;
                ki  = 65535;
                imx = 50;
                imn = -50;
                lim = 500;
                per = 1;
            end
            3:
            begin
                tgt = $urandom;
                kp  = $urandom;
                ki  = $urandom;
                imx = $urandom;
                imn = $urandom;
                lim = $urandom;
                per = $urandom;
            end
            4:
            begin
                // crossed integral bounds, zero period
                tgt = int'($urandom_range(2000)) - 1000;
                kp  = $urandom_range(4095);
                ki  = $urandom_range(4095);
                imx = -200;
                imn = 200;
                lim = $urandom_range(32767);
                per = 0;
            end
            default:
            begin
                tgt = -1024;
                kp  = 1;
                ki  = 1;
                imx = -32768;
                imn = -32768;
                lim = 2000;
                per = 2;
            end
        endcase
        write_reg(wsp_pkg::REG_SPEED_TARGET, 16'(tgt));
        write_reg(wsp_pkg::REG_PROP_GAIN, 16'(kp));
        write_reg(wsp_pkg::REG_INTEG_GAIN, 16'(ki));
        write_reg(wsp_pkg::REG_INTEG_MAX, 16'(imx));
        write_reg(wsp_pkg::REG_INTEG_MIN, 16'(imn));
        write_reg(wsp_pkg::REG_SPEED_LIMIT, 16'(lim));
        write_reg(wsp_pkg::REG_SMOOTH_PERIOD, 16'(per));
    endtask

    task automatic check_result(input logic [wsp_pkg::WHEEL_W-1:0] wh,
                                input wsp_pkg::word_t value);
        ctrl_t e;
        if (ctrl_expected.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("result word with none expected: wheel %0d value %0d", wh, value);
            return;
        end
        e = ctrl_expected.pop_front();
        words_checked++;
        if (e.wheel !== wh || e.value !== value)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("mismatch on result %0d: wheel exp %0d got %0d, value exp %0d got %0d",
                         words_checked, e.wheel, wh, e.value, value);
        end
    endtask

    // result side: random idling, one long hold-off
    initial
    begin
        int   hold_left;
        bit   held;
        logic rdy;
        hold_left = 0;
        held      = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.wheel_out, out_ch.control_value);
            if (!held && words_checked >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
                rdy = (words_checked >= CALM_FROM && words_checked < CALM_TO) ||
                      ($urandom_range(99) >= IDLE_PCT);
            out_ch.ready <= rdy;
        end
    end

    initial
    begin
        row_t directed [$];
        row_t r;
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.opcode         <= OP_SPEED;
        in_ch.wheel          <= '0;
        in_ch.measured_speed <= '0;
        in_ch.slot           <= '0;
        reg_ch.valid         <= 1'b0;
        reg_ch.index         <= wsp_pkg::REG_SPEED_TARGET;
        reg_ch.data          <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero gains give zero output, out of limit speeds count as zero
        directed.push_back(word_row(OP_INTERP, 2'd0, 16'sd0, 8'd0, 1'b1, 32'sd0));
        directed.push_back(word_row(OP_SPEED, 2'd1, 16'sd500, 8'd0, 1'b1, 32'sd0));
        directed.push_back(word_row(OP_SPEED, 2'd2, 16'sh7FFF, 8'd0, 1'b1, 32'sd0));
        directed.push_back(word_row(OP_SPEED, 2'd0, 16'sh8000, 8'd0, 1'b1, 32'sd0));
        // unity proportional gain, full target
        directed.push_back(reg_row(wsp_pkg::REG_SPEED_TARGET, 16'd1000));
        directed.push_back(reg_row(wsp_pkg::REG_PROP_GAIN, 16'h0100));
        directed.push_back(word_row(OP_SPEED, 2'd3, 16'sd0, 8'd0, 1'b1, 32'sd256000));
        directed.push_back(word_row(OP_INTERP, 2'd3, 16'sd0, 8'd19, 1'b1, 32'sd256000));
        directed.push_back(word_row(OP_INTERP, 2'd3, 16'sd0, 8'd9, 1'b1, 32'sd128000));
        directed.push_back(word_row(OP_INTERP, 2'd3, 16'sd0, 8'd255, 1'b0, '0));
        // speed at both ends of the limit and beyond it
        directed.push_back(word_row(OP_SPEED, 2'd1, 16'sd1000, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_SPEED, 2'd1, -16'sd1000, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_SPEED, 2'd1, 16'sd1001, 8'd0, 1'b0, '0));
        // full gains, tight integral clamp, filter saturation
        directed.push_back(reg_row(wsp_pkg::REG_PROP_GAIN, 16'hFFFF));
        directed.push_back(reg_row(wsp_pkg::REG_INTEG_GAIN, 16'hFFFF));
        directed.push_back(reg_row(wsp_pkg::REG_INTEG_MAX, 16'd100));
        directed.push_back(reg_row(wsp_pkg::REG_INTEG_MIN, 16'hFF9C));
        directed.push_back(reg_row(wsp_pkg::REG_SPEED_TARGET, 16'h0400));
        directed.push_back(reg_row(wsp_pkg::REG_SPEED_LIMIT, 16'h7FFF));
        directed.push_back(word_row(OP_SPEED, 2'd2, 16'sh7FFF, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_SPEED, 2'd2, 16'sh8000, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_SPEED, 2'd2, 16'sh7FFF, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_INTERP, 2'd2, 16'sd0, 8'd255, 1'b0, '0));
        // crossed integral bounds, zero period
        directed.push_back(reg_row(wsp_pkg::REG_INTEG_MAX, 16'hFFFB));
        directed.push_back(reg_row(wsp_pkg::REG_INTEG_MIN, 16'd5));
        directed.push_back(reg_row(wsp_pkg::REG_SMOOTH_PERIOD, 16'd0));
        directed.push_back(word_row(OP_SPEED, 2'd0, -16'sd32767, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_INTERP, 2'd0, 16'sd0, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_INTERP, 2'd0, 16'sd0, 8'd128, 1'b0, '0));
        // longest period, zero speed limit
        directed.push_back(reg_row(wsp_pkg::REG_SMOOTH_PERIOD, 16'd255));
        directed.push_back(reg_row(wsp_pkg::REG_SPEED_LIMIT, 16'd0));
        directed.push_back(word_row(OP_SPEED, 2'd3, 16'sd1, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_SPEED, 2'd3, 16'sd0, 8'd0, 1'b0, '0));
        directed.push_back(word_row(OP_INTERP, 2'd3, 16'sd0, 8'd254, 1'b0, '0));
        directed.push_back(word_row(OP_INTERP, 2'd1, 16'sd0, 8'hAA, 1'b0, '0));

        foreach (directed[i])
        begin
            r = directed[i];
            if (r.kind == ROW_REG)
            begin
                drain();
                write_reg(r.idx, r.data);
            end
            else
                offer_word(r.op, r.wheel, r.speed, r.slot, r.typed, r.value);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain();
            load_setting(ph);
            repeat (PHASE_WORDS) offer_random_word();
        end

        drain();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && ctrl_expected.size() == 0)
            $display("[wheel_speed_pi_loop_core] OK");
        else
            $display("[wheel_speed_pi_loop_core] ERROR");
        $finish;
    end

endmodule
